/* hdl/gads_pkg.sv */
// Shared types and constants for the graph adjacency and degree store.
package gads_pkg;

	localparam int NODE_W = 6;
	localparam int VC_W   = 7;
	localparam logic [VC_W-1:0] VC_RESET = 7'd64;

	typedef enum logic [1:0] {
		ACT_CONNECT,
		ACT_DISCONNECT,
		ACT_REDUCE,
		ACT_QUERY
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_SCAN,
		ST_STAT,
		ST_FIN_RD,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic            pair_adjacent;
		logic [VC_W-1:0] degree_a;
		logic [VC_W-1:0] removed;
		logic            dirac_holds;
		logic            ore_holds;
	} result_t;

endpackage

/* hdl/graph_adjacency_degree_store_unit.sv */
// Top level of the graph adjacency and degree store.
// Holds an undirected graph of up to MAX_VERTICES vertices in one memory entry per vertex
// (adjacency row plus degree); every transaction connects, disconnects, reduces or queries and
// returns one result. One transaction at a time, in steps: accept, entry check, degree statistics
// scan over the n entries in use, final read of node_a, result; plus a read and write of both
// entries per changed edge, plus the reduce walk over node_a's row, where n is vertex_count
// limited to MAX_VERTICES. The result stage holds while the output register is full and
// stalled. The next transaction is taken while a result waits in the output register. Stored
// entries read as empty after reset through per-entry valid bits, so no clearing pass is needed.
module graph_adjacency_degree_store_unit #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gads_pkg::VC_W-1:0]         vertex_count,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        action,
	input  logic [gads_pkg::NODE_W-1:0]       node_a,
	input  logic [gads_pkg::NODE_W-1:0]       node_b,
	input  logic [gads_pkg::VC_W-1:0]         remove_count,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              pair_adjacent,
	output logic [gads_pkg::VC_W-1:0]         degree_a,
	output logic [gads_pkg::VC_W-1:0]         removed,
	output logic                              dirac_holds,
	output logic                              ore_holds
);
	import gads_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int DW = $clog2(MAX_VERTICES + 2);

	logic [VC_W-1:0] vc_q, n;
	logic            in_ready, res_valid, res_ready, out_valid_q;
	result_t         res, res_q;
	logic            rd_en, wr_en;
	logic [AW-1:0]   rd_addr, wr_addr;
	logic [MAX_VERTICES-1:0] rd_row, wr_row;
	logic [DW-1:0]   rd_deg, wr_deg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= VC_RESET;
		end else if (cfg_valid) begin
			vc_q <= vertex_count;
		end
	end

	assign n = (int'(vc_q) > MAX_VERTICES) ? VC_W'(MAX_VERTICES) : vc_q;

	gads_mem #(
		.DEPTH(MAX_VERTICES),
		.WIDTH(DW + MAX_VERTICES)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data ({wr_deg, wr_row}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data ({rd_deg, rd_row})
	);

	gads_ctrl #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.n            (n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.node_a       (node_a),
		.node_b       (node_b),
		.remove_count (remove_count),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_row       (rd_row),
		.rd_deg       (rd_deg),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_row       (wr_row),
		.wr_deg       (wr_deg)
	);

	assign in_stall  = !in_ready;
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign pair_adjacent = res_q.pair_adjacent;
	assign degree_a      = res_q.degree_a;
	assign removed       = res_q.removed;
	assign dirac_holds   = res_q.dirac_holds;
	assign ore_holds     = res_q.ore_holds;

endmodule

/* hdl/gads_mem.sv */
// Vertex store: one entry per vertex (degree and adjacency row), per-entry valid bits.
module gads_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 71
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

/* hdl/gads_ctrl.sv */
// Sequencer: read-modify-write of vertex entries, reduce scan and degree statistics scan.
module gads_ctrl #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic [gads_pkg::VC_W-1:0]                n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [1:0]                               action,
	input  logic [gads_pkg::NODE_W-1:0]              node_a,
	input  logic [gads_pkg::NODE_W-1:0]              node_b,
	input  logic [gads_pkg::VC_W-1:0]                remove_count,
	output logic                                     res_valid,
	input  logic                                     res_ready,
	output gads_pkg::result_t                        res,
	output logic                                     rd_en,
	output logic [$clog2(MAX_VERTICES)-1:0]          rd_addr,
	input  logic [MAX_VERTICES-1:0]                  rd_row,
	input  logic [$clog2(MAX_VERTICES+2)-1:0]        rd_deg,
	output logic                                     wr_en,
	output logic [$clog2(MAX_VERTICES)-1:0]          wr_addr,
	output logic [MAX_VERTICES-1:0]                  wr_row,
	output logic [$clog2(MAX_VERTICES+2)-1:0]        wr_deg
);
	import gads_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int DW = $clog2(MAX_VERTICES + 2);
	localparam int CW = AW + 1;

	state_t            state_q, state_d;
	action_t           act_q;
	logic [NODE_W-1:0] a_q, b_q;
	logic [VC_W-1:0]   want_q, removed_q;
	logic [MAX_VERTICES-1:0] row_q;
	logic [AW-1:0]     p_q, q_q;
	logic              set_q, pend_q;
	logic [CW-1:0]     idx_q;
	logic [DW-1:0]     min1_q, min2_q;
	logic              stat_s1;

	logic          accept;
	logic [AW-1:0] a_addr, b_addr;
	logic          a_in_use, b_in_use, a_in_store, b_in_store;
	logic          idx_lt_n, more_wanted, edge_ab, do_change, scan_hit;

	assign accept     = in_valid && in_ready;
	assign a_addr     = AW'(a_q);
	assign b_addr     = AW'(b_q);
	assign a_in_use   = {1'b0, a_q} < n;
	assign b_in_use   = {1'b0, b_q} < n;
	assign a_in_store = int'(a_q) < MAX_VERTICES;
	assign b_in_store = int'(b_q) < MAX_VERTICES;
	assign idx_lt_n   = int'(idx_q) < int'(n);
	assign more_wanted = removed_q < want_q;
	assign edge_ab    = rd_row[b_addr];
	assign do_change  = a_in_use && b_in_use &&
		((act_q == ACT_CONNECT && !edge_ab) || (act_q == ACT_DISCONNECT && edge_ab));
	assign scan_hit   = row_q[idx_q[AW-1:0]];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CHK;
			end
			ST_CHK: begin
				if (do_change) state_d = ST_UPD_RD;
				else if (act_q == ACT_REDUCE && a_in_use) state_d = ST_SCAN;
				else state_d = ST_STAT;
			end
			ST_UPD_RD: state_d = ST_UPD_WR;
			ST_UPD_WR: begin
				if (pend_q) state_d = ST_UPD_RD;
				else if (act_q == ACT_REDUCE) state_d = ST_SCAN;
				else state_d = ST_STAT;
			end
			ST_SCAN: begin
				if (idx_lt_n && more_wanted) begin
					if (scan_hit) state_d = ST_UPD_RD;
				end else begin
					state_d = ST_STAT;
				end
			end
			ST_STAT: begin
				if (!idx_lt_n) state_d = ST_FIN_RD;
			end
			ST_FIN_RD: state_d = ST_FIN;
			ST_FIN: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = a_addr;
		wr_en     = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				rd_en    = in_valid;
				rd_addr  = AW'(node_a);
			end
			ST_UPD_RD: begin
				rd_en   = 1'b1;
				rd_addr = p_q;
			end
			ST_UPD_WR: wr_en = 1'b1;
			ST_STAT: begin
				rd_en   = idx_lt_n;
				rd_addr = idx_q[AW-1:0];
			end
			ST_FIN_RD: rd_en = 1'b1;
			ST_FIN: res_valid = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		wr_row        = rd_row;
		wr_row[q_q]   = set_q;
	end
	assign wr_addr = p_q;
	assign wr_deg  = set_q ? rd_deg + DW'(1) : rd_deg - DW'(1);

	assign res.pair_adjacent = a_in_store && b_in_store && rd_row[b_addr];
	assign res.degree_a      = a_in_store ? VC_W'(rd_deg) : '0;
	assign res.removed       = removed_q;
	assign res.dirac_holds   = (n == '0) ||
		(int'(min1_q) >= ((int'(n) + 1) >> 1));
	assign res.ore_holds     = (int'(n) < 2) ||
		((int'(min1_q) + int'(min2_q)) >= int'(n));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stat_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			stat_s1 <= (state_q == ST_STAT) && idx_lt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q     <= action_t'(action);
			a_q       <= node_a;
			b_q       <= node_b;
			want_q    <= remove_count;
			removed_q <= '0;
			min1_q    <= '1;
			min2_q    <= '1;
		end
		if (stat_s1) begin
			if (rd_deg < min1_q) begin
				min2_q <= min1_q;
				min1_q <= rd_deg;
			end else if (rd_deg < min2_q) begin
				min2_q <= rd_deg;
			end
		end
		case (state_q)
			ST_CHK: begin
				row_q  <= rd_row;
				p_q    <= a_addr;
				q_q    <= b_addr;
				set_q  <= act_q == ACT_CONNECT;
				pend_q <= 1'b1;
				idx_q  <= '0;
			end
			ST_UPD_WR: begin
				if (pend_q) begin
					p_q    <= q_q;
					q_q    <= p_q;
					pend_q <= 1'b0;
				end
			end
			ST_SCAN: begin
				if (idx_lt_n && more_wanted) begin
					idx_q <= idx_q + CW'(1);
					if (scan_hit) begin
						removed_q <= removed_q + VC_W'(1);
						p_q       <= a_addr;
						q_q       <= idx_q[AW-1:0];
						set_q     <= 1'b0;
						pend_q    <= 1'b1;
					end
				end else begin
					idx_q <= '0;
				end
			end
			ST_STAT: begin
				if (idx_lt_n) idx_q <= idx_q + CW'(1);
			end
			default: ;
		endcase
	end

	a_accept_chk: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_CHK)
		else $error("accepted transaction did not start entry check");
	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> $past(state_q) == ST_UPD_RD)
		else $error("entry write without preceding read");
	a_removed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && act_q != ACT_REDUCE |-> res.removed == '0)
		else $error("removed count nonzero outside reduce");
	a_removed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.removed <= want_q)
		else $error("removed more edges than requested");

endmodule

/* bench/tb_graph_adjacency_degree_store_unit.sv */
// Self-checking bench for the graph adjacency and degree store: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_graph_adjacency_degree_store_unit;
	import gads_pkg::*;

	localparam int NV = 64;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		action_t         act;
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
		logic [VC_W-1:0]   cnt;
		logic            typed;
		result_t         res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [VC_W-1:0] vertex_count = VC_RESET;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] action = '0;
	logic [NODE_W-1:0] node_a = '0;
	logic [NODE_W-1:0] node_b = '0;
	logic [VC_W-1:0] remove_count = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic pair_adjacent;
	logic [VC_W-1:0] degree_a;
	logic [VC_W-1:0] removed;
	logic dirac_holds;
	logic ore_holds;

	graph_adjacency_degree_store_unit #(.MAX_VERTICES(NV)) u_dut (.*);

	// graph mirror
	logic [NV-1:0] adj_mirror [NV];
	int unsigned deg_mirror [NV];
	int unsigned used_n = 64;

	result_t result_q [$];
	int errors = 0;
	int n_sent = 0;
	int n_got = 0;
	int idle_cycles = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void graph_clear();
		for (int i = 0; i < NV; i++) begin
			adj_mirror[i] = '0;
			deg_mirror[i] = 0;
		end
	endfunction

	function automatic void edge_set(int x, int y);
		if (!adj_mirror[x][y]) begin
			adj_mirror[x][y] = 1'b1;
			adj_mirror[y][x] = 1'b1;
			deg_mirror[x]++;
			deg_mirror[y]++;
		end
	endfunction

	function automatic void edge_clr(int x, int y);
		if (adj_mirror[x][y]) begin
			adj_mirror[x][y] = 1'b0;
			adj_mirror[y][x] = 1'b0;
			deg_mirror[x]--;
			deg_mirror[y]--;
		end
	endfunction

	function automatic result_t graph_step(action_t act, int x, int y, int cnt);
		result_t r;
		int unsigned rem;
		longint unsigned m1, m2;
		rem = 0;
		if (act == ACT_CONNECT && x < used_n && y < used_n)
			edge_set(x, y);
		else if (act == ACT_DISCONNECT && x < used_n && y < used_n)
			edge_clr(x, y);
		else if (act == ACT_REDUCE && x < used_n) begin
			for (int i = 0; i < used_n && rem < cnt; i++)
				if (adj_mirror[x][i]) begin
					edge_clr(x, i);
					rem++;
				end
		end
		m1 = 64'hFFFF_FFFF;
		m2 = 64'hFFFF_FFFF;
		for (int i = 0; i < used_n; i++) begin
			if (deg_mirror[i] < m1) begin
				m2 = m1;
				m1 = deg_mirror[i];
			end else if (deg_mirror[i] < m2)
				m2 = deg_mirror[i];
		end
		r.pair_adjacent = adj_mirror[x][y];
		r.degree_a = deg_mirror[x][VC_W-1:0];
		r.removed = rem[VC_W-1:0];
		r.dirac_holds = (used_n == 0) || (m1 >= (used_n + 1) / 2);
		r.ore_holds = (used_n < 2) || (m1 + m2 >= used_n);
		return r;
	endfunction

	task automatic send_op(action_t act, int x, int y, int cnt, logic typed, result_t tr);
		result_t r;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		node_a <= x[NODE_W-1:0];
		node_b <= y[NODE_W-1:0];
		remove_count <= cnt[VC_W-1:0];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = graph_step(act, x, y, cnt);
		if (typed && r !== tr) begin
			$display("%0t table row disagrees with predictor: table %h predictor %h",
				$time, tr, r);
			errors++;
		end
		result_q.push_back(r);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (result_q.size() != 0) @(negedge clk);
		repeat (3 * NV + 20) @(negedge clk);
	endtask

	task automatic write_vc(int v);
		cfg_valid <= 1'b1;
		vertex_count <= v[VC_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		used_n = (v > NV) ? NV : v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			result_t exp_r;
			if (result_q.size() == 0) begin
				$display("%0t unexpected result: expected none actual %b %0d %0d %b %b", $time,
					pair_adjacent, degree_a, removed, dirac_holds, ore_holds);
				errors++;
			end else begin
				exp_r = result_q.pop_front();
				n_got++;
				if (pair_adjacent !== exp_r.pair_adjacent) begin
					$display("%0t pair_adjacent: expected %b actual %b", $time,
						exp_r.pair_adjacent, pair_adjacent);
					errors++;
				end
				if (degree_a !== exp_r.degree_a) begin
					$display("%0t degree_a: expected %0d actual %0d", $time,
						exp_r.degree_a, degree_a);
					errors++;
				end
				if (removed !== exp_r.removed) begin
					$display("%0t removed: expected %0d actual %0d", $time,
						exp_r.removed, removed);
					errors++;
				end
				if (dirac_holds !== exp_r.dirac_holds) begin
					$display("%0t dirac_holds: expected %b actual %b", $time,
						exp_r.dirac_holds, dirac_holds);
					errors++;
				end
				if (ore_holds !== exp_r.ore_holds) begin
					$display("%0t ore_holds: expected %b actual %b", $time,
						exp_r.ore_holds, ore_holds);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) out_stall <= ($urandom_range(99) < snk_idle_pct);

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("%0t watchdog expired", $time);
			$display("graph_adjacency_degree_store_unit test failed");
			$finish;
		end
	end

	function automatic result_t mk(logic p, int d, int rm, logic di, logic o);
		result_t r;
		r.pair_adjacent = p;
		r.degree_a = d[VC_W-1:0];
		r.removed = rm[VC_W-1:0];
		r.dirac_holds = di;
		r.ore_holds = o;
		return r;
	endfunction

	task automatic random_phase(int items, int vc_max);
		int x, y, hub;
		action_t act;
		hub = $urandom_range(vc_max - 1);
		for (int k = 0; k < items; k++) begin
			x = $urandom_range(vc_max - 1);
			y = $urandom_range(vc_max - 1);
			if ($urandom_range(9) == 0) x = $urandom_range(63);
			if ($urandom_range(9) == 0) y = $urandom_range(63);
			if ($urandom_range(3) == 0) x = hub;
			case ($urandom_range(9))
				0, 1, 2, 3: act = ACT_CONNECT;
				4, 5: act = ACT_DISCONNECT;
				6: act = ACT_REDUCE;
				default: act = ACT_QUERY;
			endcase
			send_op(act, x, y, ($urandom_range(3) == 0) ? $urandom_range(127) :
				$urandom_range(4), 1'b0, '0);
			if (k == items / 2 && $urandom_range(1)) begin
				in_valid <= 1'b0;
				while (result_q.size() != 0) @(negedge clk);
			end
		end
	endtask

	stim_row_t dir_rows [] = '{
		'{ACT_QUERY, 6'd0, 6'd0, 7'd0, 1'b1, 17'h0},
		'{ACT_QUERY, 6'd63, 6'd63, 7'd127, 1'b1, 17'h0},
		'{ACT_CONNECT, 6'd0, 6'd63, 7'd0, 1'b0, 17'h0},
		'{ACT_CONNECT, 6'd0, 6'd63, 7'd0, 1'b0, 17'h0},
		'{ACT_CONNECT, 6'd5, 6'd5, 7'd0, 1'b0, 17'h0},
		'{ACT_CONNECT, 6'd5, 6'd0, 7'd64, 1'b0, 17'h0},
		'{ACT_DISCONNECT, 6'd63, 6'd0, 7'd0, 1'b0, 17'h0},
		'{ACT_DISCONNECT, 6'd63, 6'd0, 7'd0, 1'b0, 17'h0},
		'{ACT_CONNECT, 6'd5, 6'd42, 7'd0, 1'b0, 17'h0},
		'{ACT_REDUCE, 6'd5, 6'd21, 7'd0, 1'b0, 17'h0},
		'{ACT_REDUCE, 6'd5, 6'd21, 7'd2, 1'b0, 17'h0},
		'{ACT_REDUCE, 6'd5, 6'd5, 7'd127, 1'b0, 17'h0},
		'{ACT_QUERY, 6'd42, 6'd5, 7'd0, 1'b0, 17'h0}
	};

	initial begin
		graph_clear();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		src_idle_pct = 29;
		snk_idle_pct = 82;
		foreach (dir_rows[i]) begin
			result_t tr;
			tr = mk(dir_rows[i].res.pair_adjacent, 0, 0, 1'b0, 1'b0);
			send_op(dir_rows[i].act, dir_rows[i].a, dir_rows[i].b, dir_rows[i].cnt,
				dir_rows[i].typed, tr);
		end
		drain();
		// small graph: flags can actually be met, plus out-of-use vertices
		write_vc(3);
		send_op(ACT_CONNECT, 0, 1, 0, 1'b0, '0);
		send_op(ACT_CONNECT, 1, 2, 0, 1'b0, '0);
		send_op(ACT_CONNECT, 2, 0, 0, 1'b0, '0);
		send_op(ACT_CONNECT, 3, 0, 0, 1'b0, '0);
		send_op(ACT_REDUCE, 42, 0, 5, 1'b0, '0);
		drain();
		write_vc(0);
		send_op(ACT_CONNECT, 0, 1, 0, 1'b1, mk(1'b1, 2, 0, 1'b1, 1'b1));
		send_op(ACT_REDUCE, 0, 0, 64, 1'b1, mk(1'b0, 2, 0, 1'b1, 1'b1));
		drain();
		write_vc(1);
		send_op(ACT_CONNECT, 0, 0, 0, 1'b0, '0);
		send_op(ACT_REDUCE, 0, 0, 1, 1'b0, '0);
		drain();
		write_vc(127);
		random_phase(200, 64);
		drain();
		src_idle_pct = 82;
		snk_idle_pct = 29;
		write_vc(4);
		random_phase(150, 4);
		drain();
		write_vc(9);
		random_phase(150, 9);
		drain();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_vc(64);
		random_phase(250, 64);
		drain();
		$display("covered %0d transactions, %0d results, vertex counts 0,1,3,4,9,64,127",
			n_sent, n_got);
		$display("with connect, disconnect, reduce, query, self-loops and idle/stall mixes");
		if (errors == 0 && result_q.size() == 0)
			$display("graph_adjacency_degree_store_unit test passed");
		else
			$display("graph_adjacency_degree_store_unit test failed");
		$finish;
	end

endmodule

/* sim.f */
hdl/gads_pkg.sv
hdl/gads_mem.sv
hdl/gads_ctrl.sv
hdl/graph_adjacency_degree_store_unit.sv
bench/tb_graph_adjacency_degree_store_unit.sv
